[rtl/pst_pkg.sv]
// Shared types and codes for the process status table.
package pst_pkg;

  localparam int unsigned EXIT_W   = 16;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_TERMINATE = 2'd1,
    REQ_REMOVE    = 2'd2,
    REQ_SEARCH    = 2'd3
  } req_e;

  localparam logic [1:0] MODE_KEEP      = 2'd0;
  localparam logic [1:0] MODE_OVERWRITE = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    STS_ADDED     = 3'd0,
    STS_OK        = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_EXISTS    = 3'd3,
    STS_BAD_MODE  = 3'd4,
    STS_FULL      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_e;

endpackage

[rtl/process_status_table.sv]
// Process status table: keyed store of process IDs with run flag and exit status.
//
// The block holds up to TABLE_ENTRIES process IDs in a single-port-write,
// single-port-read memory. Each slot word carries a valid bit, the key, a
// running flag and a 16-bit exit status. After reset the block first sweeps
// the memory and clears every valid bit, one slot a cycle, so in_stall_o stays
// high until the sweep is done, before the first request word is taken. A
// request is then handled one at a time: the sequencer walks every slot
// through the one read port and one key comparator, remembering the lowest
// matching slot and the lowest free slot, and then performs the single
// write-back (insert, revive, mark terminated or remove) and loads the result
// word. A request passes through the idle state that accepts it, the scan
// state that reads every slot and inspects each registered read word, and
// the decision state. The result sits in an output register, so the next
// request word is accepted while the previous
// result still waits; a new result only stalls in the decision cycle if the
// old one has not been taken yet. entry_count_o reports the number of valid
// slots after the request. Only the low KEY_BITS bits of the process ID form
// the key.
module process_status_table #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned KEY_BITS      = 22
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // request channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [1:0]                              req_type_i,
  input  logic [KEY_BITS-1:0]                     proc_id_i,
  input  logic [1:0]                              insert_mode_i,
  input  logic [pst_pkg::EXIT_W-1:0]              exit_code_i,
  // result channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [pst_pkg::STATUS_W-1:0]            status_code_o,
  output logic                                    entry_running_o,
  output logic [pst_pkg::EXIT_W-1:0]              entry_exit_o,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0]      entry_count_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] NumEntries = CntW'(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx    = IdxW'(TABLE_ENTRIES - 1);

  // One memory word per slot.
  typedef struct packed {
    logic                       valid;
    logic [KEY_BITS-1:0]        key;
    logic                       running;
    logic [pst_pkg::EXIT_W-1:0] exit_val;
  } slot_t;

  slot_t slot_mem [TABLE_ENTRIES];
  slot_t rdata_q;

  // Sequencer and request registers.
  pst_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  scan_q, scan_d;        // slot being read (also clear pointer)
  logic             rd_pend_q, rd_pend_d;  // rdata_q holds a slot to inspect
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;

  pst_pkg::req_e              req_q;
  logic [KEY_BITS-1:0]        key_q;
  logic [1:0]                 mode_q;
  logic [pst_pkg::EXIT_W-1:0] code_q;

  // Scan findings.
  logic                       hit_q, hit_d;
  logic [IdxW-1:0]            hit_idx_q, hit_idx_d;
  logic                       hit_run_q, hit_run_d;
  logic [pst_pkg::EXIT_W-1:0] hit_exit_q, hit_exit_d;
  logic                       free_q, free_d;
  logic [IdxW-1:0]            free_idx_q, free_idx_d;

  logic [CntW-1:0] count_q, count_d;

  // Result register.
  logic                       out_valid_q, out_valid_d;
  pst_pkg::status_e           status_q, status_d;
  logic                       run_q, run_d;
  logic [pst_pkg::EXIT_W-1:0] exit_q, exit_d;
  logic [CntW-1:0]            ocount_q, ocount_d;

  // Memory write port.
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  slot_t           mem_wdata;

  logic in_accept;
  logic out_free;

  assign in_stall_o = (state_q != pst_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // The result register can take a new word this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    rd_pend_d  = 1'b0;
    rd_idx_d   = rd_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_run_d  = hit_run_q;
    hit_exit_d = hit_exit_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    count_d    = count_q;
    mem_we     = 1'b0;
    mem_waddr  = scan_q[IdxW-1:0];
    mem_wdata  = '0;

    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    run_d       = run_q;
    exit_d      = exit_q;
    ocount_d    = ocount_q;

    unique case (state_q)
      pst_pkg::ST_CLEAR: begin
        // Sweep every slot and drop its valid bit.
        mem_we = 1'b1;
        scan_d = scan_q + CntW'(1);
        if (scan_q[IdxW-1:0] == LastIdx) begin
          state_d = pst_pkg::ST_IDLE;
        end
      end

      pst_pkg::ST_IDLE: begin
        if (in_accept) begin
          scan_d  = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = pst_pkg::ST_SCAN;
        end
      end

      pst_pkg::ST_SCAN: begin
        // Issue the next read.
        if (scan_q != NumEntries) begin
          rd_pend_d = 1'b1;
          rd_idx_d  = scan_q[IdxW-1:0];
          scan_d    = scan_q + CntW'(1);
        end
        // Inspect the slot read last cycle; keep the lowest hit and free slot.
        if (rd_pend_q) begin
          if (rdata_q.valid && (rdata_q.key == key_q) && !hit_q) begin
            hit_d      = 1'b1;
            hit_idx_d  = rd_idx_q;
            hit_run_d  = rdata_q.running;
            hit_exit_d = rdata_q.exit_val;
          end
          if (!rdata_q.valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
          if (rd_idx_q == LastIdx) begin
            state_d = pst_pkg::ST_DECIDE;
          end
        end
      end

      pst_pkg::ST_DECIDE: begin
        // Hold here until the result register is free, then commit once.
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = pst_pkg::ST_IDLE;
          run_d       = hit_run_q;
          exit_d      = hit_exit_q;
          mem_waddr   = hit_idx_q;
          if (!hit_q) begin
            run_d  = 1'b0;
            exit_d = '0;
          end
          unique case (req_q)
            pst_pkg::REQ_INSERT: begin
              if (hit_q) begin
                case (mode_q)
                  pst_pkg::MODE_KEEP: status_d = pst_pkg::STS_EXISTS;
                  pst_pkg::MODE_OVERWRITE: begin
                    status_d  = pst_pkg::STS_OK;
                    run_d     = 1'b1;
                    mem_we    = 1'b1;
                    mem_wdata = '{valid: 1'b1, key: key_q, running: 1'b1,
                                  exit_val: hit_exit_q};
                  end
                  default: status_d = pst_pkg::STS_BAD_MODE;
                endcase
              end else if (free_q) begin
                status_d  = pst_pkg::STS_ADDED;
                run_d     = 1'b1;
                exit_d    = '0;
                mem_we    = 1'b1;
                mem_waddr = free_idx_q;
                mem_wdata = '{valid: 1'b1, key: key_q, running: 1'b1, exit_val: '0};
                count_d   = count_q + CntW'(1);
              end else begin
                status_d = pst_pkg::STS_FULL;
              end
            end
            pst_pkg::REQ_TERMINATE: begin
              if (hit_q) begin
                status_d  = pst_pkg::STS_OK;
                run_d     = 1'b0;
                exit_d    = code_q;
                mem_we    = 1'b1;
                mem_wdata = '{valid: 1'b1, key: key_q, running: 1'b0, exit_val: code_q};
              end else begin
                status_d = pst_pkg::STS_NOT_FOUND;
              end
            end
            pst_pkg::REQ_REMOVE: begin
              if (hit_q) begin
                status_d  = pst_pkg::STS_OK;
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (count_q != '0) begin
                  count_d = count_q - CntW'(1);
                end
              end else begin
                status_d = pst_pkg::STS_NOT_FOUND;
              end
            end
            pst_pkg::REQ_SEARCH: begin
              status_d = hit_q ? pst_pkg::STS_OK : pst_pkg::STS_NOT_FOUND;
            end
            default: status_d = pst_pkg::STS_NOT_FOUND;
          endcase
          ocount_d = count_d;
        end
      end

      default: state_d = pst_pkg::ST_CLEAR;
    endcase
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= slot_mem[scan_q[IdxW-1:0]];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pst_pkg::ST_CLEAR;
      scan_q      <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      rd_pend_q   <= rd_pend_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q  <= pst_pkg::req_e'(req_type_i);
      key_q  <= proc_id_i;
      mode_q <= insert_mode_i;
      code_q <= exit_code_i;
    end
    rd_idx_q   <= rd_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_run_q  <= hit_run_d;
    hit_exit_q <= hit_exit_d;
    free_idx_q <= free_idx_d;
    status_q   <= status_d;
    run_q      <= run_d;
    exit_q     <= exit_d;
    ocount_q   <= ocount_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_code_o   = status_q;
  assign entry_running_o = run_q;
  assign entry_exit_o    = exit_q;
  assign entry_count_o   = ocount_q;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the process status table: directed table, a fill sequence, then random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS         = 64;
  localparam int unsigned KEY_W         = 22;
  localparam int unsigned CNT_W         = $clog2(SLOTS + 1);
  localparam int unsigned POOL_KEYS     = 96;
  localparam int unsigned FILL_WORDS    = SLOTS + 6;
  localparam int unsigned RANDOM_WORDS  = 680;
  localparam int unsigned CALM_WORDS    = 100;
  localparam int unsigned PHASE_WORDS   = 120;
  localparam int unsigned SHOWN_ERRORS  = 10;
  // covers one request's scan of all SLOTS slots plus the longest sender gap and receiver stall
  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 2 * SLOTS + 8;

  // insert modes the block rejects on an existing key
  localparam logic [1:0] MODE_BAD_LO = 2'd2;
  localparam logic [1:0] MODE_BAD_HI = 2'd3;

  localparam logic [KEY_W-1:0] PID_MIN  = '0;
  localparam logic [KEY_W-1:0] PID_MAX  = '1;
  localparam logic [KEY_W-1:0] PID_ALT1 = 22'h2AAAAA;
  localparam logic [KEY_W-1:0] PID_ALT0 = 22'h155555;

  typedef struct packed {
    pst_pkg::status_e           sts;
    logic                       run;
    logic [pst_pkg::EXIT_W-1:0] ex;
    logic [CNT_W-1:0]           cnt;
  } result_t;

  typedef struct packed {
    pst_pkg::req_e              req;
    logic [KEY_W-1:0]           pid;
    logic [1:0]                 mode;
    logic [pst_pkg::EXIT_W-1:0] code;
    logic                       known;  // 1: want is typed in, 0: take the predictor's word
    result_t                    want;
  } step_t;

  // Directed walk: misses on an empty table, inserts in every mode, terminate,
  // revive keeping the exit status, remove and lookups after removal.
  // The table-full case follows in the fill sequence.
  localparam step_t PLAN [24] = '{
    '{pst_pkg::REQ_SEARCH,    PID_MIN,  pst_pkg::MODE_KEEP,      16'h0000, 1'b1,
      '{pst_pkg::STS_NOT_FOUND, 1'b0, 16'h0000, 7'd0}},
    '{pst_pkg::REQ_TERMINATE, PID_MAX,  pst_pkg::MODE_KEEP,      16'hFFFF, 1'b1,
      '{pst_pkg::STS_NOT_FOUND, 1'b0, 16'h0000, 7'd0}},
    '{pst_pkg::REQ_REMOVE,    PID_ALT0, MODE_BAD_HI,             16'h1234, 1'b1,
      '{pst_pkg::STS_NOT_FOUND, 1'b0, 16'h0000, 7'd0}},
    '{pst_pkg::REQ_INSERT,    PID_MIN,  pst_pkg::MODE_KEEP,      16'hFFFF, 1'b1,
      '{pst_pkg::STS_ADDED,     1'b1, 16'h0000, 7'd1}},
    '{pst_pkg::REQ_INSERT,    PID_MAX,  MODE_BAD_HI,             16'h0000, 1'b1,
      '{pst_pkg::STS_ADDED,     1'b1, 16'h0000, 7'd2}},
    '{pst_pkg::REQ_INSERT,    PID_ALT1, MODE_BAD_LO,             16'h0000, 1'b1,
      '{pst_pkg::STS_ADDED,     1'b1, 16'h0000, 7'd3}},
    '{pst_pkg::REQ_INSERT,    PID_MIN,  pst_pkg::MODE_KEEP,      16'h0000, 1'b1,
      '{pst_pkg::STS_EXISTS,    1'b1, 16'h0000, 7'd3}},
    '{pst_pkg::REQ_INSERT,    PID_MIN,  MODE_BAD_LO,             16'h0000, 1'b1,
      '{pst_pkg::STS_BAD_MODE,  1'b1, 16'h0000, 7'd3}},
    '{pst_pkg::REQ_TERMINATE, PID_MIN,  pst_pkg::MODE_KEEP,      16'hFFFF, 1'b1,
      '{pst_pkg::STS_OK,        1'b0, 16'hFFFF, 7'd3}},
    '{pst_pkg::REQ_SEARCH,    PID_MIN,  pst_pkg::MODE_OVERWRITE, 16'h0000, 1'b1,
      '{pst_pkg::STS_OK,        1'b0, 16'hFFFF, 7'd3}},
    '{pst_pkg::REQ_INSERT,    PID_MIN,  MODE_BAD_HI,             16'h0000, 1'b1,
      '{pst_pkg::STS_BAD_MODE,  1'b0, 16'hFFFF, 7'd3}},
    '{pst_pkg::REQ_INSERT,    PID_MIN,  pst_pkg::MODE_KEEP,      16'h0000, 1'b1,
      '{pst_pkg::STS_EXISTS,    1'b0, 16'hFFFF, 7'd3}},
    '{pst_pkg::REQ_INSERT,    PID_MIN,  pst_pkg::MODE_OVERWRITE, 16'h0000, 1'b1,
      '{pst_pkg::STS_OK,        1'b1, 16'hFFFF, 7'd3}},
    '{pst_pkg::REQ_TERMINATE, PID_MAX,  pst_pkg::MODE_KEEP,      16'h0000, 1'b1,
      '{pst_pkg::STS_OK,        1'b0, 16'h0000, 7'd3}},
    '{pst_pkg::REQ_TERMINATE, PID_MAX,  pst_pkg::MODE_KEEP,      16'h5A5A, 1'b0, '0},
    '{pst_pkg::REQ_REMOVE,    PID_MAX,  pst_pkg::MODE_KEEP,      16'h0000, 1'b1,
      '{pst_pkg::STS_OK,        1'b0, 16'h5A5A, 7'd2}},
    '{pst_pkg::REQ_SEARCH,    PID_MAX,  pst_pkg::MODE_KEEP,      16'h0000, 1'b1,
      '{pst_pkg::STS_NOT_FOUND, 1'b0, 16'h0000, 7'd2}},
    '{pst_pkg::REQ_INSERT,    PID_ALT0, pst_pkg::MODE_OVERWRITE, 16'h0000, 1'b1,
      '{pst_pkg::STS_ADDED,     1'b1, 16'h0000, 7'd3}},
    '{pst_pkg::REQ_REMOVE,    PID_MIN,  pst_pkg::MODE_KEEP,      16'h0000, 1'b1,
      '{pst_pkg::STS_OK,        1'b1, 16'hFFFF, 7'd2}},
    '{pst_pkg::REQ_REMOVE,    PID_MIN,  pst_pkg::MODE_KEEP,      16'h0000, 1'b1,
      '{pst_pkg::STS_NOT_FOUND, 1'b0, 16'h0000, 7'd2}},
    '{pst_pkg::REQ_TERMINATE, PID_ALT1, pst_pkg::MODE_KEEP,      16'hA5A5, 1'b1,
      '{pst_pkg::STS_OK,        1'b0, 16'hA5A5, 7'd2}},
    '{pst_pkg::REQ_INSERT,    PID_ALT1, pst_pkg::MODE_OVERWRITE, 16'h0000, 1'b0, '0},
    '{pst_pkg::REQ_REMOVE,    PID_ALT1, pst_pkg::MODE_KEEP,      16'h0000, 1'b1,
      '{pst_pkg::STS_OK,        1'b1, 16'hA5A5, 7'd1}},
    '{pst_pkg::REQ_REMOVE,    PID_ALT0, pst_pkg::MODE_KEEP,      16'h0000, 1'b1,
      '{pst_pkg::STS_OK,        1'b1, 16'h0000, 7'd0}}
  };

  // block ports
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    req_type_i    = '0;
  logic [KEY_W-1:0]              proc_id_i     = '0;
  logic [1:0]                    insert_mode_i = '0;
  logic [pst_pkg::EXIT_W-1:0]    exit_code_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i   = 1'b0;
  logic [pst_pkg::STATUS_W-1:0]  status_code_o;
  logic                          entry_running_o;
  logic [pst_pkg::EXIT_W-1:0]    entry_exit_o;
  logic [CNT_W-1:0]              entry_count_o;

  // predictor's copy of the table
  logic                          slot_used   [SLOTS];
  logic [KEY_W-1:0]              slot_pid    [SLOTS];
  logic                          slot_alive  [SLOTS];
  logic [pst_pkg::EXIT_W-1:0]    slot_status [SLOTS];
  int unsigned                   used_slots  = 0;

  result_t              pending_results [$];
  int unsigned          mismatches    = 0;
  int unsigned          quiet_cycles  = 0;
  int unsigned          stall_left    = 0;
  logic                 calm          = 1'b0;
  logic                 timed_out     = 1'b0;

  always #2 clk_i = ~clk_i;

  process_status_table #(
    .TABLE_ENTRIES (SLOTS),
    .KEY_BITS      (KEY_W)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .proc_id_i       (proc_id_i),
    .insert_mode_i   (insert_mode_i),
    .exit_code_i     (exit_code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_code_o   (status_code_o),
    .entry_running_o (entry_running_o),
    .entry_exit_o    (entry_exit_o),
    .entry_count_o   (entry_count_o)
  );

  // Apply one request to the table copy and return the result word it gives.
  function automatic result_t predict_request(pst_pkg::req_e req, logic [KEY_W-1:0] pid,
                                              logic [1:0] mode,
                                              logic [pst_pkg::EXIT_W-1:0] code);
    int      hit  = -1;
    int      hole = -1;
    result_t res  = '0;
    // walk downward so the lowest matching and lowest free slot win
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_pid[i] == pid) hit = i;
      if (!slot_used[i]) hole = i;
    end
    res.sts = pst_pkg::STS_NOT_FOUND;
    if (req == pst_pkg::REQ_INSERT) begin
      if (hit < 0) begin
        // new key: mode does not matter, only room does
        if (hole < 0) begin
          res.sts = pst_pkg::STS_FULL;
        end else begin
          slot_used[hole]   = 1'b1;
          slot_pid[hole]    = pid;
          slot_alive[hole]  = 1'b1;
          slot_status[hole] = '0;
          used_slots++;
          res.sts = pst_pkg::STS_ADDED;
          res.run = 1'b1;
        end
      end else begin
        case (mode)
          pst_pkg::MODE_KEEP: res.sts = pst_pkg::STS_EXISTS;
          pst_pkg::MODE_OVERWRITE: begin
            slot_alive[hit] = 1'b1;  // revive, exit status stays
            res.sts = pst_pkg::STS_OK;
          end
          default: res.sts = pst_pkg::STS_BAD_MODE;
        endcase
        res.run = slot_alive[hit];
        res.ex  = slot_status[hit];
      end
    end else if (hit >= 0) begin
      res.sts = pst_pkg::STS_OK;
      if (req == pst_pkg::REQ_TERMINATE) begin
        slot_alive[hit]  = 1'b0;
        slot_status[hit] = code;
      end
      // a removed entry reports what it held just before removal
      res.run = slot_alive[hit];
      res.ex  = slot_status[hit];
      if (req == pst_pkg::REQ_REMOVE) begin
        slot_used[hit] = 1'b0;
        used_slots--;
      end
    end
    res.cnt = CNT_W'(used_slots);
    return res;
  endfunction

  // Drive one request word, hold it until taken, then queue its expected result.
  task automatic send_request(pst_pkg::req_e req, logic [KEY_W-1:0] pid, logic [1:0] mode,
                              logic [pst_pkg::EXIT_W-1:0] code, logic known,
                              result_t want);
    result_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    proc_id_i     <= pid;
    insert_mode_i <= mode;
    exit_code_i   <= code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // the word went in at this edge; the table copy advances with it
    predicted = predict_request(req, pid, mode, code);
    pending_results.push_back(known ? want : predicted);
  endtask

  // Stall the result side in random bursts; hold off when calm.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 8);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Count cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Check every taken result word against the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_code_o, entry_running_o, entry_exit_o, entry_count_o};
      if (pending_results.size() == 0) begin
        if (mismatches < SHOWN_ERRORS)
          $display("%0t: unexpected result word: status %0d running %0d exit %h count %0d",
                   $realtime, got.sts, got.run, got.ex, got.cnt);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatches < SHOWN_ERRORS)
            $display("%0t: mismatch exp/act: sts %0d/%0d run %0d/%0d exit %h/%h cnt %0d/%0d",
                     $realtime, want.sts, got.sts, want.run, got.run, want.ex, got.ex,
                     want.cnt, got.cnt);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0]            pool [POOL_KEYS];
    pst_pkg::req_e               req;
    logic [KEY_W-1:0]            pid;
    logic [1:0]                  mode;
    logic [pst_pkg::EXIT_W-1:0]  code;
    int unsigned                 roll;
    int unsigned                 insert_share;

    foreach (slot_used[i]) slot_used[i] = 1'b0;
    // keep the key pool a bit larger than the table so it can fill and still miss
    pool[0] = PID_MIN;
    pool[1] = PID_MAX;
    for (int i = 2; i < POOL_KEYS; i++) pool[i] = KEY_W'($urandom);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        foreach (PLAN[i])
          send_request(PLAN[i].req, PLAN[i].pid, PLAN[i].mode, PLAN[i].code,
                       PLAN[i].known, PLAN[i].want);

        // fill the table to the brim, then knock on it a few more times
        for (int i = 0; i < FILL_WORDS; i++)
          send_request(pst_pkg::REQ_INSERT, pool[i], 2'($urandom_range(0, 3)),
                       pst_pkg::EXIT_W'($urandom), 1'b0, '0);

        // random traffic in phases that drain, churn and refill the table
        for (int n = 0; n < RANDOM_WORDS; n++) begin
          calm = (n >= RANDOM_WORDS - CALM_WORDS);
          case ((n / PHASE_WORDS) % 3)
            0:       insert_share = 20;
            1:       insert_share = 45;
            default: insert_share = 70;
          endcase
          if ($urandom_range(0, 99) < insert_share) req = pst_pkg::REQ_INSERT;
          else req = pst_pkg::req_e'($urandom_range(1, 3));
          // mostly known keys, some stray ones that miss
          if ($urandom_range(0, 9) == 0) pid = KEY_W'($urandom);
          else pid = pool[$urandom_range(0, POOL_KEYS - 1)];
          roll = $urandom_range(0, 9);
          if (roll < 4) mode = pst_pkg::MODE_KEEP;
          else if (roll < 8) mode = pst_pkg::MODE_OVERWRITE;
          else mode = $urandom_range(0, 1) ? MODE_BAD_HI : MODE_BAD_LO;
          roll = $urandom_range(0, 15);
          if (roll == 0) code = '0;
          else if (roll == 1) code = '1;
          else code = pst_pkg::EXIT_W'($urandom);
          send_request(req, pid, mode, code, 1'b0, '0);
        end
        in_valid_i <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk_i);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
      end
      begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
        $display("%0t: watchdog expired, %0d result words outstanding",
                 $realtime, pending_results.size());
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
